### rtl/core/urlj_pkg.sv
// Package for the URL-encoded to JSON stream converter.
// Holds the parser mode type, character constants, the expansion record
// and the hex digit helper. Depends on nothing.
package urlj_pkg;

  // Parser modes, one-hot.
  typedef enum logic [5:0] {
    MODE_BEGIN = 6'b000001,
    MODE_SKIP  = 6'b000010,
    MODE_KEY   = 6'b000100,
    MODE_VALUE = 6'b001000,
    MODE_ESC1  = 6'b010000,
    MODE_ESC2  = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_L   = 8'h6C;

  // Hex digit formula constants.
  localparam logic [7:0] HEX_LC_LO   = 8'h61;
  localparam logic [7:0] HEX_LC_HI   = 8'h66;
  localparam logic [7:0] HEX_CASE    = 8'h20;
  localparam logic [7:0] HEX_ZERO    = 8'h30;
  localparam logic [7:0] HEX_TEN     = 8'h10;
  localparam logic [7:0] HEX_ALPHA   = 8'h07;

  // One item expands to at most sixteen bytes.
  localparam int EXP_BYTES = 16;
  localparam int EXP_W     = EXP_BYTES * 8;
  localparam int CNT_W     = 5;

  // Bytes of one item, first byte in the top bits.
  typedef struct packed {
    logic [EXP_W-1:0] data;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } exp_t;

  function automatic logic [7:0] hex_digit(input logic [7:0] d);
    logic [7:0] v;
    v = d;
    if (v >= HEX_LC_LO && v <= HEX_LC_HI) v = v - HEX_CASE;
    if (v >= HEX_ZERO) v = v - HEX_ZERO;
    if (v >= HEX_TEN) v = v - HEX_ALPHA;
    return v;
  endfunction

endpackage

### rtl/core/urlj_if.sv
// Request channel interfaces of the URL-encoded to JSON stream converter.
// Input bytes and output bytes, each with valid and ready. No dependencies.
interface urlj_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urlj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### rtl/core/urlj_parser.sv
// Parser state and byte expansion for the URL-encoded to JSON converter.
// Turns one accepted input byte into up to fifteen output bytes.
// Depends on urlj_pkg.
module urlj_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output urlj_pkg::exp_t  exp
);
  import urlj_pkg::*;

  mode_t      mode_r, mode_nxt;
  logic       esc_r, esc_nxt;
  logic [3:0] nib_r, nib_nxt;

  mode_t       eff_mode;
  logic [15:0] pre_v;
  logic [1:0]  pre_n;
  logic [63:0] mid_v;
  logic [3:0]  mid_n;
  logic [55:0] suf_v;
  logic [2:0]  suf_n;
  logic [7:0]  hex_b;
  logic [7:0]  dec;
  logic [7:0]  src;
  logic [15:0] ec_v;
  logic [3:0]  ec_n;
  logic [3:0]  pm_n;
  logic        in_val;

  // Escaped-or-plain character emission shared by the skip, key, value and second escape modes.
  always_comb begin
    hex_b = hex_digit(in_byte);
    dec   = {nib_r, 4'b0000} + hex_b;
    if (mode_r == MODE_ESC2) src = dec;
    else if (in_byte == CH_PLUS) src = CH_SPACE;
    else src = in_byte;
    if (src == CH_QUOTE || src == CH_BSLASH) begin
      ec_v = {CH_BSLASH, src};
      ec_n = 4'd2;
    end else begin
      ec_v = {src, 8'h00};
      ec_n = 4'd1;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    nib_nxt  = nib_r;
    pre_v    = '0;
    pre_n    = '0;
    mid_v    = '0;
    mid_n    = '0;
    suf_v    = '0;
    suf_n    = '0;
    in_val   = 1'b0;

    case (mode_r)
      MODE_SKIP, MODE_KEY, MODE_VALUE, MODE_ESC1, MODE_ESC2: begin
        eff_mode = mode_r;
      end
      default: begin
        eff_mode = MODE_SKIP;
        pre_v    = {CH_LBRACE, CH_QUOTE};
        pre_n    = 2'd2;
      end
    endcase
    mode_nxt = eff_mode;

    case (eff_mode)
      MODE_SKIP: begin
        if (in_byte != CH_EQ && in_byte != CH_AMP) begin
          mode_nxt = MODE_KEY;
          if (in_byte == CH_PCT) begin
            esc_nxt  = 1'b0;
            mode_nxt = MODE_ESC1;
          end else begin
            mid_v = {ec_v, 48'h0};
            mid_n = ec_n;
          end
        end
      end
      MODE_KEY: begin
        if (in_byte == CH_EQ) begin
          mid_v    = {CH_QUOTE, CH_COLON, CH_QUOTE, 40'h0};
          mid_n    = 4'd3;
          mode_nxt = MODE_VALUE;
        end else if (in_byte == CH_AMP) begin
          mid_v    = {CH_QUOTE, CH_COLON, CH_LC_N, CH_LC_U, CH_LC_L, CH_LC_L,
                      CH_COMMA, CH_QUOTE};
          mid_n    = 4'd8;
          mode_nxt = MODE_SKIP;
        end else if (in_byte == CH_PCT) begin
          esc_nxt  = 1'b0;
          mode_nxt = MODE_ESC1;
        end else begin
          mid_v = {ec_v, 48'h0};
          mid_n = ec_n;
        end
      end
      MODE_VALUE: begin
        if (in_byte == CH_AMP) begin
          mid_v    = {CH_QUOTE, CH_COMMA, CH_QUOTE, 40'h0};
          mid_n    = 4'd3;
          mode_nxt = MODE_SKIP;
        end else if (in_byte == CH_PCT) begin
          esc_nxt  = 1'b1;
          mode_nxt = MODE_ESC1;
        end else begin
          mid_v = {ec_v, 48'h0};
          mid_n = ec_n;
        end
      end
      MODE_ESC1: begin
        nib_nxt  = hex_b[3:0];
        mode_nxt = MODE_ESC2;
      end
      MODE_ESC2: begin
        mid_v    = {ec_v, 48'h0};
        mid_n    = ec_n;
        mode_nxt = esc_r ? MODE_VALUE : MODE_KEY;
      end
      default: begin
        mode_nxt = MODE_BEGIN;
      end
    endcase

    // The final byte closes whatever item is open; a cut-off escape is dropped.
    if (in_last) begin
      in_val = (mode_nxt == MODE_VALUE) ||
               ((mode_nxt == MODE_ESC1 || mode_nxt == MODE_ESC2) && esc_nxt);
      if (in_val) begin
        suf_v = {CH_QUOTE, CH_RBRACE, 40'h0};
        suf_n = 3'd2;
      end else begin
        suf_v = {CH_QUOTE, CH_COLON, CH_LC_N, CH_LC_U, CH_LC_L, CH_LC_L, CH_RBRACE};
        suf_n = 3'd7;
      end
      mode_nxt = MODE_BEGIN;
      esc_nxt  = 1'b0;
      nib_nxt  = 4'h0;
    end
  end

  assign pm_n = {2'b00, pre_n} + mid_n;

  always_comb begin
    exp.data = {pre_v, {(EXP_W-16){1'b0}}}
             | ({mid_v, {(EXP_W-64){1'b0}}} >> {pre_n, 3'b000})
             | ({suf_v, {(EXP_W-56){1'b0}}} >> {pm_n, 3'b000});
    exp.cnt  = {1'b0, pm_n} + {2'b00, suf_n};
    exp.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BEGIN;
      esc_r  <= 1'b0;
      nib_r  <= 4'h0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      nib_r  <= nib_nxt;
    end
  end

endmodule

### rtl/core/urlj_outbuf.sv
// Output serializer for the URL-encoded to JSON converter.
// Holds one expanded item and drains it a byte per cycle, while the output is not stalled, into an output register.
// Depends on urlj_pkg.
module urlj_outbuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  urlj_pkg::exp_t exp,
  output logic           load_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import urlj_pkg::*;

  logic [EXP_W-1:0] sbuf_r, sbuf_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;
  logic             pop;

  assign pop     = (cnt_r != '0) && (!ov_r || out_ready);
  assign load_ok = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && pop);

  always_comb begin
    sbuf_nxt = sbuf_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    ol_nxt   = ol_r;
    if (load) begin
      sbuf_nxt = exp.data;
      cnt_nxt  = exp.cnt;
      last_nxt = exp.last;
    end else if (pop) begin
      sbuf_nxt = {sbuf_r[EXP_W-9:0], 8'h00};
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
    if (pop) begin
      ov_nxt = 1'b1;
      ob_nxt = sbuf_r[EXP_W-1 -: 8];
      ol_nxt = last_r && (cnt_r == CNT_W'(1));
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sbuf_r <= sbuf_nxt;
    last_r <= last_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

endmodule

### rtl/core/urlencoded_to_json_stream.sv
// Top level of the URL-encoded to JSON stream converter.
// Instantiates urlj_parser and urlj_outbuf; uses urlj_pkg and urlj_if.
//
// This block reads a URL-encoded query string one byte per request and
// writes the text of the equivalent JSON object one byte per request. Each
// accepted input byte is expanded in the same cycle into zero to fifteen
// output bytes, which are held in a shift buffer and passed out one per
// cycle through an output register while the output is ready. Plain text,
// whose bytes yield zero or one output byte, streams the same way at one
// byte per cycle. A byte that yields more output bytes holds the input off
// until the shift buffer is down to its last byte, as that buffer drains
// through a single-byte port. An input byte with in_last set closes the
// object, and the closing brace is the only output byte with out_last set.
// Empty strings produce nothing. Bytes go out through the shift buffer and
// then the output register. Reset is synchronous and active low.
module urlencoded_to_json_stream (
  input  logic        clk,
  input  logic        rst_n,
  urlj_in_if.sink     in_ch,
  urlj_out_if.source  out_ch
);
  import urlj_pkg::*;

  exp_t exp;
  logic load_ok;
  logic acc;

  // A request is taken whenever the shift buffer is free or about to empty.
  assign in_ch.ready = load_ok;
  assign acc         = in_ch.valid && load_ok;

  urlj_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .exp     (exp)
  );

  urlj_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc),
    .exp       (exp),
    .load_ok   (load_ok),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
  );

`ifndef NO_ASSERTIONS
  // The final byte of a string always yields a closing sequence.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.in_last) |-> (exp.last && exp.cnt >= CNT_W'(2)))
    else $error("final byte did not produce a closing sequence");

  // No item expands beyond the buffer depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (exp.cnt <= CNT_W'(EXP_BYTES)))
    else $error("expansion exceeds buffer depth");

  // End of object is flagged only on the closing brace.
  a_last_brace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.out_last) |-> (out_ch.out_byte == CH_RBRACE))
    else $error("end of object flagged on a byte other than the closing brace");
`endif

endmodule
